FILE: rtl/glyph_quad_vertex_generator_assert.svh
// assertion macros for the glyph quad vertex generator checker
// expects signals named clk and rst_n in the scope of use
`ifndef GLYPH_QUAD_VERTEX_GENERATOR_ASSERT_SVH
`define GLYPH_QUAD_VERTEX_GENERATOR_ASSERT_SVH

// same-cycle implication
`define GQV_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GQV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/gqv_pkg.sv
// shared types, constants and fixed-point helpers for the glyph quad vertex generator
// no dependencies
`timescale 1ns / 1ps

package gqv_pkg;

  localparam int IN_TDATA_W  = 88;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 72;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 16;

  typedef enum logic [1:0] {
    OP_GLYPH   = 2'd0,
    OP_NEWLINE = 2'd1,
    OP_MISSING = 2'd2
  } op_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_ORIGIN_X   = 3'd0,
    REG_ORIGIN_Y   = 3'd1,
    REG_SCALE_X    = 3'd2,
    REG_SCALE_Y    = 3'd3,
    REG_LINE_STEP  = 3'd4,
    REG_INV_ATLAS_W = 3'd5,
    REG_INV_ATLAS_H = 3'd6
  } cfg_idx_t;

  localparam logic [2:0] CORNER_LL   = 3'd0;
  localparam logic [2:0] CORNER_LR   = 3'd1;
  localparam logic [2:0] CORNER_UL   = 3'd2;
  localparam logic [2:0] CORNER_UL2  = 3'd3;
  localparam logic [2:0] CORNER_LR2  = 3'd4;
  localparam logic [2:0] CORNER_LAST = 3'd5;

  localparam logic signed [15:0] RST_ORIGIN    = -16'sd4096;
  localparam logic [15:0]        RST_SCALE     = 16'd256;
  localparam logic [14:0]        RST_LINE_STEP = 15'd4096;
  localparam logic [15:0]        RST_INV_ATLAS = 16'd256;

  typedef struct packed {
    logic signed [15:0] origin_x;
    logic signed [15:0] origin_y;
    logic [15:0]        scale_x;
    logic [15:0]        scale_y;
    logic [14:0]        line_step;
    logic [15:0]        inv_w;
    logic [15:0]        inv_h;
  } cfg_t;

  typedef struct packed {
    logic [1:0]        op;
    logic              first;
    logic [7:0]        pix_w;
    logic [7:0]        pix_h;
    logic signed [7:0] bearing_x;
    logic signed [8:0] bearing_y;
    logic [7:0]        pen_dx;
    logic signed [7:0] pen_dy;
    logic [15:0]       tex_u;
    logic [15:0]       tex_v;
  } item_t;

  // scaled metrics, positional lengths rounded to q10.12; texture extents du and dv are not rounded
  typedef struct packed {
    logic [1:0]         op;
    logic               first;
    logic signed [22:0] left_q;
    logic signed [22:0] top_q;
    logic signed [22:0] size_x;
    logic signed [22:0] size_y;
    logic signed [22:0] adv_x;
    logic signed [22:0] adv_y;
    logic [23:0]        du;
    logic [23:0]        dv;
    logic [15:0]        tex_u;
    logic [15:0]        tex_v;
  } scaled_t;

  typedef struct packed {
    logic signed [15:0] x0;
    logic signed [15:0] x1;
    logic signed [15:0] y0;
    logic signed [15:0] y1;
    logic [15:0]        u0;
    logic [15:0]        u1;
    logic [15:0]        v0;
    logic [15:0]        v1;
  } quad_t;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [15:0]        coord_u;
    logic [15:0]        coord_v;
    logic [2:0]         corner;
    logic               last;
  } vtx_t;

  // q.16 to q.12, round to nearest, ties up
  function automatic logic signed [22:0] rnd_q12(input logic signed [26:0] p);
    logic signed [26:0] t;
    t = p + 27'sd8;
    return t[26:4];
  endfunction

  function automatic logic signed [15:0] sat16s(input logic signed [23:0] v);
    logic signed [15:0] r;
    if (v > 24'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -24'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  function automatic logic [15:0] sat16u(input logic [24:0] v);
    return (v > 25'd65535) ? 16'hFFFF : v[15:0];
  endfunction

endpackage

FILE: rtl/glyph_quad_vertex_generator.sv
// Glyph quad vertex generator: one character item in, six vertices out per glyph. An item
// goes through an input register, a scaling register (one multiplier per metric) and the
// pen stage into a quad register, from which its first vertex is offered. The quad
// register hands out one vertex per output transaction and loads the next glyph's quad
// as the last vertex of the one before is taken; newline and missing-glyph items pass
// at one per cycle while no glyph ahead waits for the quad register. Items keep being
// taken while a quad is still being sent. Configuration registers are written through
// cfg_we/cfg_addr/cfg_wdata, by the user only while idle; the block does not enforce it.
// depends on gqv_pkg, gqv_scale, gqv_pen, gqv_emit
`timescale 1ns / 1ps

module glyph_quad_vertex_generator (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // first, pix_w, pix_h, bearing_x, bearing_y, pen_dx,
  // pen_dy, tex_u, tex_v, zero pad
  input  logic [gqv_pkg::IN_TDATA_W-1:0]      in_tdata,
  // op
  input  logic [gqv_pkg::IN_TUSER_W-1:0]      in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // pos_x, pos_y, coord_u, coord_v, corner, zero pad
  output logic [gqv_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic                                out_tlast,
  input  logic                                cfg_we,
  input  logic [gqv_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [gqv_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import gqv_pkg::*;

  cfg_t    cfg_r, cfg_nxt;
  item_t   item;
  scaled_t scl;
  logic    scl_valid, scl_ready;
  quad_t   quad;
  logic    quad_load, quad_free;
  vtx_t    vtx;

  always_comb begin
    item.op        = in_tuser;
    item.first     = in_tdata[0];
    item.pix_w     = in_tdata[8:1];
    item.pix_h     = in_tdata[16:9];
    item.bearing_x = in_tdata[24:17];
    item.bearing_y = in_tdata[33:25];
    item.pen_dx    = in_tdata[41:34];
    item.pen_dy    = in_tdata[49:42];
    item.tex_u     = in_tdata[65:50];
    item.tex_v     = in_tdata[81:66];
  end

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        REG_ORIGIN_X:    cfg_nxt.origin_x  = cfg_wdata;
        REG_ORIGIN_Y:    cfg_nxt.origin_y  = cfg_wdata;
        REG_SCALE_X:     cfg_nxt.scale_x   = cfg_wdata;
        REG_SCALE_Y:     cfg_nxt.scale_y   = cfg_wdata;
        REG_LINE_STEP:   cfg_nxt.line_step = cfg_wdata[14:0];
        REG_INV_ATLAS_W: cfg_nxt.inv_w     = cfg_wdata;
        REG_INV_ATLAS_H: cfg_nxt.inv_h     = cfg_wdata;
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.origin_x  <= RST_ORIGIN;
      cfg_r.origin_y  <= RST_ORIGIN;
      cfg_r.scale_x   <= RST_SCALE;
      cfg_r.scale_y   <= RST_SCALE;
      cfg_r.line_step <= RST_LINE_STEP;
      cfg_r.inv_w     <= RST_INV_ATLAS;
      cfg_r.inv_h     <= RST_INV_ATLAS;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  gqv_scale u_scale (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (in_tvalid),
    .item_ready (in_tready),
    .item       (item),
    .cfg        (cfg_r),
    .scl_valid  (scl_valid),
    .scl_ready  (scl_ready),
    .scl        (scl)
  );

  gqv_pen u_pen (
    .clk       (clk),
    .rst_n     (rst_n),
    .scl_valid (scl_valid),
    .scl_ready (scl_ready),
    .scl       (scl),
    .cfg       (cfg_r),
    .quad_free (quad_free),
    .quad_load (quad_load),
    .quad      (quad)
  );

  gqv_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .quad_load (quad_load),
    .quad      (quad),
    .quad_free (quad_free),
    .vtx_valid (out_tvalid),
    .vtx_ready (out_tready),
    .vtx       (vtx)
  );

  assign out_tdata = {5'd0, vtx.corner, vtx.coord_v, vtx.coord_u, vtx.pos_y, vtx.pos_x};
  assign out_tlast = vtx.last;

endmodule

FILE: rtl/gqv_scale.sv
// input register and metric scaling stage: multiplies pixel metrics by the scale factors
// and pixel sizes by the inverse atlas sizes; depends on gqv_pkg
`timescale 1ns / 1ps

module gqv_scale (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             item_valid,
  output logic             item_ready,
  input  gqv_pkg::item_t   item,
  input  gqv_pkg::cfg_t    cfg,
  output logic             scl_valid,
  input  logic             scl_ready,
  output gqv_pkg::scaled_t scl
);
  import gqv_pkg::*;

  logic    a_valid_r, a_valid_nxt;
  item_t   a_r;
  logic    b_valid_r, b_valid_nxt;
  scaled_t b_r, b_nxt;
  logic    b_open;

  logic signed [26:0] sx_e, sy_e;
  logic signed [26:0] p_left, p_top, p_w, p_h, p_ax, p_ay;

  assign b_open     = !b_valid_r || scl_ready;
  assign item_ready = !a_valid_r || b_open;
  assign scl_valid  = b_valid_r;
  assign scl        = b_r;

  always_comb begin
    sx_e   = 27'($signed({1'b0, cfg.scale_x}));
    sy_e   = 27'($signed({1'b0, cfg.scale_y}));
    p_left = 27'($signed(a_r.bearing_x)) * sx_e;
    p_top  = 27'($signed(a_r.bearing_y)) * sy_e;
    p_w    = 27'($signed({1'b0, a_r.pix_w})) * sx_e;
    p_h    = 27'($signed({1'b0, a_r.pix_h})) * sy_e;
    p_ax   = 27'($signed({1'b0, a_r.pen_dx})) * sx_e;
    p_ay   = 27'($signed(a_r.pen_dy)) * sy_e;

    b_nxt.op     = a_r.op;
    b_nxt.first  = a_r.first;
    b_nxt.left_q = rnd_q12(p_left);
    b_nxt.top_q  = rnd_q12(p_top);
    b_nxt.size_x = rnd_q12(p_w);
    b_nxt.size_y = rnd_q12(p_h);
    b_nxt.adv_x  = rnd_q12(p_ax);
    b_nxt.adv_y  = rnd_q12(p_ay);
    b_nxt.du     = a_r.pix_w * cfg.inv_w;
    b_nxt.dv     = a_r.pix_h * cfg.inv_h;
    b_nxt.tex_u  = a_r.tex_u;
    b_nxt.tex_v  = a_r.tex_v;
  end

  always_comb begin
    a_valid_nxt = a_valid_r;
    if (item_valid && item_ready) begin
      a_valid_nxt = 1'b1;
    end else if (a_valid_r && b_open) begin
      a_valid_nxt = 1'b0;
    end
    b_valid_nxt = b_open ? a_valid_r : b_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
      b_valid_r <= b_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      a_r <= item;
    end
    if (b_open) begin
      b_r <= b_nxt;
    end
  end

endmodule

FILE: rtl/gqv_pen.sv
// pen state and quad corner computation, with saturation to q3.12 and texcoord clamping
// depends on gqv_pkg
`timescale 1ns / 1ps

module gqv_pen (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             scl_valid,
  output logic             scl_ready,
  input  gqv_pkg::scaled_t scl,
  input  gqv_pkg::cfg_t    cfg,
  input  logic             quad_free,
  output logic             quad_load,
  output gqv_pkg::quad_t   quad
);
  import gqv_pkg::*;

  logic signed [15:0] pen_x_r, pen_x_nxt;
  logic signed [15:0] pen_y_r, pen_y_nxt;
  logic signed [15:0] base_x, base_y;
  logic signed [23:0] x0w, x1w, y0w, y1w;
  logic               is_glyph, take;

  assign is_glyph  = (scl.op == OP_GLYPH);
  assign scl_ready = !is_glyph || quad_free;
  assign take      = scl_valid && scl_ready;
  assign quad_load = scl_valid && is_glyph && quad_free;

  always_comb begin
    base_x = scl.first ? cfg.origin_x : pen_x_r;
    base_y = scl.first ? cfg.origin_y : pen_y_r;

    x0w = 24'(base_x) + 24'($signed(scl.left_q));
    x1w = x0w + 24'($signed(scl.size_x));
    y0w = 24'(base_y) + 24'($signed(scl.top_q)) - 24'($signed(scl.size_y));
    y1w = y0w + 24'($signed(scl.size_y));

    quad.x0 = sat16s(x0w);
    quad.x1 = sat16s(x1w);
    quad.y0 = sat16s(y0w);
    quad.y1 = sat16s(y1w);
    quad.u0 = scl.tex_u;
    quad.u1 = sat16u({9'd0, scl.tex_u} + {1'b0, scl.du});
    quad.v1 = scl.tex_v;
    quad.v0 = sat16u({9'd0, scl.tex_v} + {1'b0, scl.dv});
  end

  always_comb begin
    pen_x_nxt = base_x;
    pen_y_nxt = base_y;
    unique case (scl.op)
      OP_GLYPH: begin
        pen_x_nxt = sat16s(24'(base_x) + 24'($signed(scl.adv_x)));
        pen_y_nxt = sat16s(24'(base_y) + 24'($signed(scl.adv_y)));
      end
      OP_NEWLINE: begin
        pen_x_nxt = cfg.origin_x;
        pen_y_nxt = sat16s(24'(base_y) - 24'($signed({1'b0, cfg.line_step})));
      end
      default: begin
        pen_x_nxt = base_x;
        pen_y_nxt = base_y;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pen_x_r <= RST_ORIGIN;
      pen_y_r <= RST_ORIGIN;
    end else if (take) begin
      pen_x_r <= pen_x_nxt;
      pen_y_r <= pen_y_nxt;
    end
  end

endmodule

FILE: rtl/gqv_emit.sv
// quad output register and corner sequencer, one vertex per transaction
// depends on gqv_pkg
`timescale 1ns / 1ps

module gqv_emit (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           quad_load,
  input  gqv_pkg::quad_t quad,
  output logic           quad_free,
  output logic           vtx_valid,
  input  logic           vtx_ready,
  output gqv_pkg::vtx_t  vtx
);
  import gqv_pkg::*;

  logic       q_valid_r, q_valid_nxt;
  quad_t      q_r;
  logic [2:0] corner_r, corner_nxt;
  logic       is_last, use_x1, use_y1;

  assign is_last   = (corner_r == CORNER_LAST);
  assign quad_free = !q_valid_r || (vtx_ready && is_last);
  assign vtx_valid = q_valid_r;

  always_comb begin
    use_x1 = (corner_r == CORNER_LR) || (corner_r == CORNER_LR2) ||
             (corner_r == CORNER_LAST);
    use_y1 = (corner_r == CORNER_UL) || (corner_r == CORNER_UL2) ||
             (corner_r == CORNER_LAST);
    vtx.pos_x   = use_x1 ? q_r.x1 : q_r.x0;
    vtx.pos_y   = use_y1 ? q_r.y1 : q_r.y0;
    vtx.coord_u = use_x1 ? q_r.u1 : q_r.u0;
    vtx.coord_v = use_y1 ? q_r.v1 : q_r.v0;
    vtx.corner  = corner_r;
    vtx.last    = is_last;
  end

  always_comb begin
    q_valid_nxt = q_valid_r;
    corner_nxt  = corner_r;
    if (quad_load) begin
      q_valid_nxt = 1'b1;
      corner_nxt  = CORNER_LL;
    end else if (q_valid_r && vtx_ready) begin
      if (is_last) begin
        q_valid_nxt = 1'b0;
      end else begin
        corner_nxt = corner_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_valid_r <= 1'b0;
      corner_r  <= CORNER_LL;
    end else begin
      q_valid_r <= q_valid_nxt;
      corner_r  <= corner_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (quad_load) begin
      q_r <= quad;
    end
  end

endmodule

FILE: rtl/gqv_checker.sv
// port-level checks on the vertex stream of the glyph quad vertex generator, bound to the top
// depends on gqv_pkg and glyph_quad_vertex_generator_assert.svh
`timescale 1ns / 1ps
`include "glyph_quad_vertex_generator_assert.svh"

module gqv_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [gqv_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                            out_tlast
);
  import gqv_pkg::*;

  logic [2:0] corner;
  logic       xfer;

  assign corner = out_tdata[66:64];
  assign xfer   = out_tvalid && out_tready;

  `GQV_ASSERT_NOW(a_last_on_final_corner, out_tvalid, out_tlast == (corner == CORNER_LAST), "tlast does not match final corner")
  `GQV_ASSERT_NEXT(a_corner_steps, xfer && !out_tlast, out_tvalid && (corner == $past(corner) + 3'd1), "corner did not advance within quad")
  `GQV_ASSERT_NEXT(a_upper_left_repeats, xfer && (corner == CORNER_UL), out_tdata[63:0] == $past(out_tdata[63:0]), "upper-left vertex not repeated")
  `GQV_ASSERT_NEXT(a_stall_holds, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast), "stalled vertex changed")

endmodule

bind glyph_quad_vertex_generator gqv_checker u_gqv_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
